[rtl/core/round_robin_quantum_scheduler_core_assert.svh]
// Assertion macros for the round-robin quantum scheduler.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RRQS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RRQS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/rrqs_pkg.sv]
// Shared types and constants for the round-robin quantum scheduler.
`timescale 1ns / 1ps
package rrqs_pkg;
   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int LEFT_W      = 16;
   localparam int SLICE_W     = 16;
   localparam int SUM_W       = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_QUANTUM  = '0;
   localparam logic [SLICE_W-1:0]    QUANTUM_RESET = SLICE_W'(1);
   localparam logic                  CMD_ARRIVE    = 1'b0;
   localparam logic                  CMD_TICK      = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [LEFT_W-1:0] left;
      logic              started;
   } slot_type;

   typedef struct packed {
      logic load;       // take the arriving item
      logic take_head;  // take the old head (rotation to tail)
      logic shift;      // take the neighbor's slot
      logic run;        // head cell: run one unit
   } cell_ctrl_type;
endpackage

[rtl/core/rrqs_cell.sv]
// One queue cell: holds a slot and hands it toward the head.
`timescale 1ns / 1ps
module rrqs_cell (
   input  logic                   clock,
   input  rrqs_pkg::cell_ctrl_type ctrl,
   input  rrqs_pkg::slot_type     nbr,
   input  rrqs_pkg::slot_type     head,
   input  rrqs_pkg::slot_type     new_slot,
   output rrqs_pkg::slot_type     slot
);
   rrqs_pkg::slot_type slot_ff;
   rrqs_pkg::slot_type slot_in;
   rrqs_pkg::slot_type base;

   always_comb begin
      if (ctrl.load) begin
         base = new_slot;
      end else if (ctrl.take_head) begin
         base = head;
      end else if (ctrl.shift) begin
         base = nbr;
      end else begin
         base = slot_ff;
      end
      slot_in = base;
      if (ctrl.run) begin
         slot_in.left    = base.left - rrqs_pkg::LEFT_W'(1);
         slot_in.started = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;
endmodule

[rtl/core/round_robin_quantum_scheduler_core.sv]
// Round-robin scheduler with time quantum: rsp_valid is registered from start.
// Throughput one item per cycle; busy is never raised, the whole cell chain
// settles, shifts and runs the head together at each clock edge.
// Synchronous reset empties the queue, clears totals and sets quantum to 1.
// Results are strobed for one cycle and cannot be held off.
`timescale 1ns / 1ps
`include "round_robin_quantum_scheduler_core_assert.svh"
module round_robin_quantum_scheduler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [rrqs_pkg::ID_W-1:0]         req_proc_id,
   input  logic [rrqs_pkg::LEFT_W-1:0]       req_burst,
   output logic                              rsp_valid,
   output logic                              rsp_accepted,
   output logic                              rsp_ran,
   output logic [rrqs_pkg::ID_W-1:0]         rsp_running_id,
   output logic [rrqs_pkg::CNT_W-1:0]        rsp_queued,
   output logic [rrqs_pkg::SUM_W-1:0]        rsp_wait_total,
   output logic [rrqs_pkg::SUM_W-1:0]        rsp_response_total,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rrqs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rrqs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rrqs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   localparam int D = rrqs_pkg::QUEUE_DEPTH;
   localparam int CW = rrqs_pkg::CNT_W;

   logic [rrqs_pkg::SLICE_W-1:0] quantum_ff, quantum_in;
   logic [rrqs_pkg::SLICE_W-1:0] slice_ff, slice_in;
   logic [CW-1:0]                occ_ff, occ_in;
   logic [CW-1:0]                unst_ff, unst_in;
   logic [rrqs_pkg::SUM_W-1:0]   wait_ff, wait_in;
   logic [rrqs_pkg::SUM_W-1:0]   resp_ff, resp_in;
   logic                         valid_ff;
   logic                         acc_ff, acc_in;
   logic                         ran_ff;
   logic [rrqs_pkg::ID_W-1:0]    run_id_ff, run_id_in;

   rrqs_pkg::slot_type slots [D];
   rrqs_pkg::slot_type nbrs  [D];
   rrqs_pkg::slot_type new_slot;
   rrqs_pkg::slot_type head_after;

   logic                         accept, arrive_ok, tick, retire, rotate, settle, run_en;
   logic [CW-1:0]                occ_after, unst_after;
   logic [rrqs_pkg::SLICE_W-1:0] reload, slice_after;
   logic [rrqs_pkg::SUM_W:0]     wait_sum, resp_sum;
   logic                         csr_wr;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr == rrqs_pkg::ADDR_QUANTUM)
                   ? rrqs_pkg::CSR_DATA_W'(quantum_ff) : '0;
   assign quantum_in = (csr_wr && paddr == rrqs_pkg::ADDR_QUANTUM)
                       ? pwdata[rrqs_pkg::SLICE_W-1:0] : quantum_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      reload    = (quantum_ff == '0) ? rrqs_pkg::SLICE_W'(1) : quantum_ff;
      tick      = accept && (req_cmd == rrqs_pkg::CMD_TICK);
      arrive_ok = accept && (req_cmd == rrqs_pkg::CMD_ARRIVE) && (req_burst != '0)
                  && (occ_ff < CW'(D));
      retire    = tick && (occ_ff != '0) && (slots[0].left == '0);
      rotate    = tick && (occ_ff != '0) && (slots[0].left != '0) && (slice_ff == '0);
      settle    = retire || rotate;
      occ_after = retire ? occ_ff - CW'(1) : (arrive_ok ? occ_ff + CW'(1) : occ_ff);
      run_en    = tick && (occ_after != '0);
      // a lone head that rotates lands back in cell 0
      if (rotate && occ_ff == CW'(1)) begin
         head_after = slots[0];
      end else if (settle) begin
         head_after = slots[1];
      end else begin
         head_after = slots[0];
      end
      slice_after = (settle || slice_ff == '0) ? reload : slice_ff;
      slice_in    = slice_ff;
      if (retire) begin
         slice_in = reload;
      end
      if (run_en) begin
         slice_in = slice_after - rrqs_pkg::SLICE_W'(1);
      end
      unst_after = arrive_ok ? unst_ff + CW'(1) : unst_ff;
      if (run_en && !head_after.started && unst_ff != '0) begin
         unst_after = unst_ff - CW'(1);
      end
      unst_in  = unst_after;
      occ_in   = occ_after;
      wait_sum = {1'b0, wait_ff} + (rrqs_pkg::SUM_W + 1)'(occ_after - CW'(1));
      resp_sum = {1'b0, resp_ff} + (rrqs_pkg::SUM_W + 1)'(unst_after);
      wait_in  = wait_ff;
      resp_in  = resp_ff;
      if (run_en) begin
         wait_in = wait_sum[rrqs_pkg::SUM_W] ? '1 : wait_sum[rrqs_pkg::SUM_W-1:0];
         resp_in = resp_sum[rrqs_pkg::SUM_W] ? '1 : resp_sum[rrqs_pkg::SUM_W-1:0];
      end
      acc_in    = tick || arrive_ok;
      run_id_in = run_en ? head_after.id : '0;
      new_slot.id      = req_proc_id;
      new_slot.left    = req_burst;
      new_slot.started = 1'b0;
   end

   // cell chain, cell 0 is the head
   for (genvar i = 0; i < D; i++) begin : g_cell
      localparam logic [CW-1:0] POS  = CW'(i);
      localparam logic [CW-1:0] POS1 = CW'(i + 1);
      rrqs_pkg::cell_ctrl_type ctrl;

      if (i == D - 1) begin : g_last
         assign nbrs[i] = '0;
      end else begin : g_mid
         assign nbrs[i] = slots[i + 1];
      end

      always_comb begin
         ctrl.load      = arrive_ok && (occ_ff == POS);
         ctrl.take_head = rotate && (occ_ff == POS1);
         ctrl.shift     = settle;
         ctrl.run       = run_en && (i == 0);
      end

      rrqs_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .nbr      (nbrs[i]),
         .head     (slots[0]),
         .new_slot (new_slot),
         .slot     (slots[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrqs_pkg::QUANTUM_RESET;
         slice_ff   <= rrqs_pkg::QUANTUM_RESET;
         occ_ff     <= '0;
         unst_ff    <= '0;
         wait_ff    <= '0;
         resp_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         quantum_ff <= quantum_in;
         slice_ff   <= slice_in;
         occ_ff     <= occ_in;
         unst_ff    <= unst_in;
         wait_ff    <= wait_in;
         resp_ff    <= resp_in;
         valid_ff   <= accept;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      ran_ff    <= run_en;
      run_id_ff <= run_id_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_ran            = ran_ff;
   assign rsp_running_id     = run_id_ff;
   assign rsp_queued         = occ_ff;
   assign rsp_wait_total     = wait_ff;
   assign rsp_response_total = resp_ff;

   `RRQS_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= CW'(D))
   `RRQS_ASSERT_IMPLY(a_unst_bound, clock, reset, 1'b1, unst_ff <= occ_ff)
   `RRQS_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid)
   `RRQS_ASSERT_IMPLY(a_ran_nonempty, clock, reset, rsp_valid && rsp_ran, rsp_queued != '0)
endmodule

[tb/sv/round_robin_quantum_scheduler_core_tb.sv]
// Self-checking testbench for the round-robin quantum scheduler core.
`timescale 1ns / 1ps
module round_robin_quantum_scheduler_core_tb;

   localparam int CYCLE_LIMIT = 200_000;

   typedef struct packed {
      logic                          accepted;
      logic                          ran;
      logic [rrqs_pkg::ID_W-1:0]     running_id;
      logic [rrqs_pkg::CNT_W-1:0]    queued;
      logic [rrqs_pkg::SUM_W-1:0]    wait_total;
      logic [rrqs_pkg::SUM_W-1:0]    response_total;
   } sched_report_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_cmd = rrqs_pkg::CMD_ARRIVE;
   logic [rrqs_pkg::ID_W-1:0]       req_proc_id = '0;
   logic [rrqs_pkg::LEFT_W-1:0]     req_burst = '0;
   logic                            rsp_valid;
   logic                            rsp_accepted;
   logic                            rsp_ran;
   logic [rrqs_pkg::ID_W-1:0]       rsp_running_id;
   logic [rrqs_pkg::CNT_W-1:0]      rsp_queued;
   logic [rrqs_pkg::SUM_W-1:0]      rsp_wait_total;
   logic [rrqs_pkg::SUM_W-1:0]      rsp_response_total;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [rrqs_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [rrqs_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [rrqs_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   round_robin_quantum_scheduler_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_proc_id        (req_proc_id),
      .req_burst          (req_burst),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_ran            (rsp_ran),
      .rsp_running_id     (rsp_running_id),
      .rsp_queued         (rsp_queued),
      .rsp_wait_total     (rsp_wait_total),
      .rsp_response_total (rsp_response_total),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scheduler state as the testbench sees it
   logic [rrqs_pkg::SLICE_W-1:0] quantum_reg;
   logic [rrqs_pkg::ID_W-1:0]    ready_id [rrqs_pkg::QUEUE_DEPTH];
   logic [rrqs_pkg::LEFT_W-1:0]  ready_left [rrqs_pkg::QUEUE_DEPTH];
   logic                         ready_started [rrqs_pkg::QUEUE_DEPTH];
   int unsigned                  head_slot, tail_slot, ready_count, never_ran_count;
   logic [rrqs_pkg::SLICE_W-1:0] slice_remaining;
   logic [rrqs_pkg::SUM_W-1:0]   wait_acc, response_acc;

   sched_report_type predicted_reports [$];

   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned reports_checked = 0;
   int unsigned rejected_count = 0;
   int unsigned ran_count = 0;
   int unsigned quantum_writes = 0;
   bit          idle_enabled = 1'b1;

   function automatic int unsigned next_slot(int unsigned p);
      return (p + 1 >= rrqs_pkg::QUEUE_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic logic [rrqs_pkg::SLICE_W-1:0] slice_reload();
      return (quantum_reg == '0) ? rrqs_pkg::SLICE_W'(1) : quantum_reg;
   endfunction

   function automatic logic [rrqs_pkg::SUM_W-1:0] sat_sum(logic [rrqs_pkg::SUM_W-1:0] acc,
                                                          int unsigned add);
      logic [rrqs_pkg::SUM_W:0] s;
      s = {1'b0, acc} + (rrqs_pkg::SUM_W + 1)'(add);
      return s[rrqs_pkg::SUM_W] ? '1 : s[rrqs_pkg::SUM_W-1:0];
   endfunction

   task automatic reset_schedule_state();
      quantum_reg = rrqs_pkg::QUANTUM_RESET;
      head_slot = 0;
      tail_slot = 0;
      ready_count = 0;
      never_ran_count = 0;
      slice_remaining = rrqs_pkg::QUANTUM_RESET;
      wait_acc = '0;
      response_acc = '0;
   endtask

   // Applies one item to the scheduler state and returns the report it should produce.
   function automatic sched_report_type advance_schedule(logic cmd,
                                                         logic [rrqs_pkg::ID_W-1:0] pid,
                                                         logic [rrqs_pkg::LEFT_W-1:0] burst);
      sched_report_type r;
      r = '0;
      r.accepted = 1'b1;
      if (cmd == rrqs_pkg::CMD_ARRIVE) begin
         if (burst == '0 || ready_count >= rrqs_pkg::QUEUE_DEPTH) begin
            r.accepted = 1'b0;
         end else begin
            ready_id[tail_slot] = pid;
            ready_left[tail_slot] = burst;
            ready_started[tail_slot] = 1'b0;
            tail_slot = next_slot(tail_slot);
            ready_count++;
            never_ran_count++;
         end
      end else if (ready_count > 0) begin
         if (ready_left[head_slot] == '0) begin
            head_slot = next_slot(head_slot);
            ready_count--;
            slice_remaining = slice_reload();
         end else if (slice_remaining == '0) begin
            // rotate: goes behind any arrivals already queued
            ready_id[tail_slot] = ready_id[head_slot];
            ready_left[tail_slot] = ready_left[head_slot];
            ready_started[tail_slot] = ready_started[head_slot];
            head_slot = next_slot(head_slot);
            tail_slot = next_slot(tail_slot);
            slice_remaining = slice_reload();
         end
         if (ready_count > 0) begin
            if (slice_remaining == '0) slice_remaining = slice_reload();
            r.ran = 1'b1;
            r.running_id = ready_id[head_slot];
            ready_left[head_slot] = ready_left[head_slot] - 1'b1;
            slice_remaining = slice_remaining - 1'b1;
            if (!ready_started[head_slot]) begin
               ready_started[head_slot] = 1'b1;
               if (never_ran_count > 0) never_ran_count--;
            end
            wait_acc = sat_sum(wait_acc, ready_count - 1);
            response_acc = sat_sum(response_acc, never_ran_count);
         end
      end
      r.queued = rrqs_pkg::CNT_W'(ready_count);
      r.wait_total = wait_acc;
      r.response_total = response_acc;
      return r;
   endfunction

   // Drives one item, waits for it to be taken, records the prediction, maybe idles.
   task automatic send_item(logic cmd, logic [rrqs_pkg::ID_W-1:0] pid,
                            logic [rrqs_pkg::LEFT_W-1:0] burst);
      sched_report_type r;
      start <= 1'b1;
      req_cmd <= cmd;
      req_proc_id <= pid;
      req_burst <= burst;
      do @(posedge clock); while (busy !== 1'b0);
      r = advance_schedule(cmd, pid, burst);
      predicted_reports.push_back(r);
      items_sent++;
      if (!r.accepted) rejected_count++;
      if (r.ran) ran_count++;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (predicted_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_quantum(logic [rrqs_pkg::SLICE_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= rrqs_pkg::ADDR_QUANTUM;
      pwdata <= rrqs_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      quantum_reg = value;
      quantum_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[rrqs_pkg::SLICE_W-1:0] !== value) begin
         $error("quantum readback: expected %0d, got %0d", value,
                prdata[rrqs_pkg::SLICE_W-1:0]);
         fail_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_random(int unsigned arrive_pct, bit long_bursts);
      logic [rrqs_pkg::LEFT_W-1:0] burst;
      if ($urandom_range(0, 19) == 0) burst = '0;
      else if (long_bursts && $urandom_range(0, 7) == 0) burst = rrqs_pkg::LEFT_W'($urandom);
      else burst = rrqs_pkg::LEFT_W'($urandom_range(1, 6));
      send_item(($urandom_range(0, 99) < arrive_pct) ? rrqs_pkg::CMD_ARRIVE : rrqs_pkg::CMD_TICK,
                rrqs_pkg::ID_W'($urandom), burst);
   endtask

   task automatic test_empty_queue();
      send_item(rrqs_pkg::CMD_TICK, '0, '0);
      send_item(rrqs_pkg::CMD_ARRIVE, 16'h1234, '0);
      send_item(rrqs_pkg::CMD_TICK, '1, '1);
   endtask

   task automatic test_fill_and_overflow();
      for (int i = 0; i < rrqs_pkg::QUEUE_DEPTH; i++) begin
         send_item(rrqs_pkg::CMD_ARRIVE,
                   (i == 0) ? rrqs_pkg::ID_W'(0) : (i == 1) ? '1 : rrqs_pkg::ID_W'($urandom),
                   (i == 2) ? rrqs_pkg::LEFT_W'(1) : rrqs_pkg::LEFT_W'($urandom_range(1, 3)));
      end
      send_item(rrqs_pkg::CMD_ARRIVE, 16'hA5A5, '1);
      send_item(rrqs_pkg::CMD_ARRIVE, 16'h5A5A, '0);
      send_item(rrqs_pkg::CMD_TICK, '0, '0);
      send_item(rrqs_pkg::CMD_ARRIVE, 16'h0F0F, 16'd2);
      send_item(rrqs_pkg::CMD_TICK, '0, '0);
      send_item(rrqs_pkg::CMD_ARRIVE, 16'hF0F0, 16'd1);
   endtask

   // Each setting is written with the queue left as the previous phase leaves it,
   // so a slice in progress sees the new quantum only at its next reload.
   task automatic test_quantum_settings();
      logic [rrqs_pkg::SLICE_W-1:0] settings [6];
      settings = '{'0, '1, rrqs_pkg::SLICE_W'(2), rrqs_pkg::SLICE_W'(3),
                   rrqs_pkg::SLICE_W'(1), rrqs_pkg::SLICE_W'($urandom_range(4, 20))};
      foreach (settings[k]) begin
         wait_idle();
         program_quantum(settings[k]);
         idle_enabled = (k != 3);
         for (int i = 0; i < 100; i++) send_random((i < 50) ? 65 : 25, 1'b0);
      end
      idle_enabled = 1'b1;
   endtask

   task automatic test_long_bursts();
      wait_idle();
      program_quantum(rrqs_pkg::SLICE_W'($urandom_range(1, 4)));
      idle_enabled = 1'b0;
      for (int i = 0; i < 80; i++) send_random(50, 1'b1);
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      sched_report_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (predicted_reports.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            want = predicted_reports.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            compare_field("ran", 32'(want.ran), 32'(rsp_ran));
            compare_field("running_id", 32'(want.running_id), 32'(rsp_running_id));
            compare_field("queued", 32'(want.queued), 32'(rsp_queued));
            compare_field("wait_total", want.wait_total, rsp_wait_total);
            compare_field("response_total", want.response_total, rsp_response_total);
            reports_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout with %0d results outstanding", predicted_reports.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset_schedule_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_and_overflow();
      test_quantum_settings();
      test_long_bursts();
      wait_idle();
      repeat (4) @(posedge clock);
      if (predicted_reports.size() != 0) begin
         $error("%0d results never arrived", predicted_reports.size());
         fail_count++;
      end
      $display("Run: %0d items, %0d results checked, %0d quantum writes.",
               items_sent, reports_checked, quantum_writes);
      $display("Run: %0d arrivals rejected, %0d ticks ran a process, %0d mismatches.",
               rejected_count, ran_count, fail_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
